// ===== rtl/mbt_pkg.sv =====
package mbt_pkg;

  // Test geometry.
  localparam int ADDR_LINES = 12;
  localparam int DATA_BITS  = 8;
  localparam int LINE_W     = (ADDR_LINES > 1) ? $clog2(ADDR_LINES) : 1;
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(ADDR_LINES - 1);

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int OKIND_W = 3;
  localparam int PHYS_W  = 20;
  localparam int OFS_W   = 12;
  localparam int LOFS_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int SEG_W   = 16;

  // Patterns and limits.
  localparam logic [BYTE_W-1:0] PAT_HI    = 8'hAA;
  localparam logic [BYTE_W-1:0] PAT_LO    = 8'h55;
  localparam logic [OFS_W-1:0]  RANGE_END = 12'h800;
  localparam logic [SEG_W-1:0]  SEG_RESET = 16'h0280;

  // Output queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Input kinds.
  localparam logic [KIND_W-1:0] IN_START = 2'd0;
  localparam logic [KIND_W-1:0] IN_ACK   = 2'd1;
  localparam logic [KIND_W-1:0] IN_DATA  = 2'd2;

  // Result kinds.
  localparam logic [OKIND_W-1:0] OUT_WR        = 3'd0;
  localparam logic [OKIND_W-1:0] OUT_RD        = 3'd1;
  localparam logic [OKIND_W-1:0] OUT_DATA_REP  = 3'd2;
  localparam logic [OKIND_W-1:0] OUT_ADDR_REP  = 3'd3;
  localparam logic [OKIND_W-1:0] OUT_RANGE_REP = 3'd4;
  localparam logic [OKIND_W-1:0] OUT_DONE      = 3'd5;

  // One result item.
  typedef struct packed {
    logic [OKIND_W-1:0] kind;
    logic [PHYS_W-1:0]  phys;
    logic [OFS_W-1:0]   offset;
    logic [BYTE_W-1:0]  data;
    logic               pass;
    logic               last;
  } res_t;

  // Offset that exercises one address line.
  function automatic logic [LOFS_W-1:0] line_off(input logic [LINE_W-1:0] k);
    line_off = LOFS_W'(1) << k;
  endfunction

  // Build a result; the physical address wraps at 20 bits.
  function automatic res_t make_res(input logic [OKIND_W-1:0] k,
                                    input logic [LOFS_W-1:0]  off,
                                    input logic [BYTE_W-1:0]  d,
                                    input logic               p,
                                    input logic               has_addr,
                                    input logic [SEG_W-1:0]   seg);
    res_t r;
    r.kind   = k;
    r.phys   = has_addr ? ({seg, 4'h0} + {4'h0, off}) : '0;
    r.offset = has_addr ? off[OFS_W-1:0] : '0;
    r.data   = d;
    r.pass   = p;
    r.last   = 1'b0;
    make_res = r;
  endfunction

endpackage

// ===== rtl/mbt_seq.sv =====
module mbt_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic [mbt_pkg::KIND_W-1:0]   kind,
  input  logic [mbt_pkg::BYTE_W-1:0]   rd,
  input  logic [mbt_pkg::SEG_W-1:0]    base_seg,
  output mbt_pkg::res_t                res0,
  output mbt_pkg::res_t                res1,
  output logic [1:0]                   res_cnt
);

  typedef enum logic [3:0] {
    S_IDLE, S_DL_W, S_DL_R, S_AF_W, S_AZ_W, S_AH_R, S_AR0_W,
    S_AD_W, S_AL_R, S_ARS_W, S_RG_W, S_RG_R
  } state_t;

  state_t                            state_r, state_nxt;
  logic [mbt_pkg::OFS_W-1:0]         index_r, index_nxt;
  logic [mbt_pkg::LINE_W-1:0]        lut_r, lut_nxt;
  logic [mbt_pkg::LINE_W-1:0]        lbr_r, lbr_nxt;

  logic [mbt_pkg::OFS_W-1:0]         idx_inc;
  logic [mbt_pkg::LINE_W-1:0]        idx_line;
  logic [mbt_pkg::LINE_W-1:0]        idx_line_inc;
  logic [mbt_pkg::BYTE_W-1:0]        pat_cur, pat_next;
  logic                              ack, dat, hi_ok;
  logic [mbt_pkg::OFS_W-1:0]         last_line_w;
  mbt_pkg::res_t                     r0, r1;
  logic [1:0]                        cnt;

  assign ack          = (kind == mbt_pkg::IN_ACK);
  assign dat          = (kind == mbt_pkg::IN_DATA);
  assign hi_ok        = (rd == mbt_pkg::PAT_HI);
  assign idx_inc      = index_r + 1'b1;
  assign idx_line     = index_r[mbt_pkg::LINE_W-1:0];
  assign idx_line_inc = idx_inc[mbt_pkg::LINE_W-1:0];
  assign pat_cur      = mbt_pkg::BYTE_W'(1) << index_r[2:0];
  assign pat_next     = mbt_pkg::BYTE_W'(1) << idx_inc[2:0];
  assign last_line_w  = mbt_pkg::OFS_W'(mbt_pkg::LAST_LINE);

  // Next-access decision for the current response.
  always_comb begin
    state_nxt = state_r;
    index_nxt = index_r;
    lut_nxt   = lut_r;
    lbr_nxt   = lbr_r;
    r0        = '0;
    r1        = '0;
    cnt       = 2'd0;
    case (state_r)
      S_IDLE: begin
        if (kind == mbt_pkg::IN_START) begin
          index_nxt = '0;
          state_nxt = S_DL_W;
          r0  = mbt_pkg::make_res(mbt_pkg::OUT_WR, '0, 8'h01, 1'b0, 1'b1, base_seg);
          cnt = 2'd1;
        end
      end
      S_DL_W: begin
        if (ack) begin
          state_nxt = S_DL_R;
          r0  = mbt_pkg::make_res(mbt_pkg::OUT_RD, '0, '0, 1'b0, 1'b1, base_seg);
          cnt = 2'd1;
        end
      end
      S_DL_R: begin
        if (dat) begin
          r0  = mbt_pkg::make_res(mbt_pkg::OUT_DATA_REP, '0, pat_cur, rd == pat_cur,
                                  1'b1, base_seg);
          cnt = 2'd2;
          if (index_r < mbt_pkg::OFS_W'(mbt_pkg::DATA_BITS - 1)) begin
            index_nxt = idx_inc;
            state_nxt = S_DL_W;
            r1 = mbt_pkg::make_res(mbt_pkg::OUT_WR, '0, pat_next, 1'b0, 1'b1, base_seg);
          end else begin
            index_nxt = '0;
            state_nxt = S_AF_W;
            r1 = mbt_pkg::make_res(mbt_pkg::OUT_WR, mbt_pkg::line_off('0), mbt_pkg::PAT_HI,
                                   1'b0, 1'b1, base_seg);
          end
        end
      end
      S_AF_W: begin
        if (ack) begin
          cnt = 2'd1;
          if (index_r < last_line_w) begin
            index_nxt = idx_inc;
            r0 = mbt_pkg::make_res(mbt_pkg::OUT_WR, mbt_pkg::line_off(idx_line_inc),
                                   mbt_pkg::PAT_HI, 1'b0, 1'b1, base_seg);
          end else begin
            state_nxt = S_AZ_W;
            r0 = mbt_pkg::make_res(mbt_pkg::OUT_WR, '0, mbt_pkg::PAT_LO, 1'b0, 1'b1,
                                   base_seg);
          end
        end
      end
      S_AZ_W: begin
        if (ack) begin
          index_nxt = '0;
          state_nxt = S_AH_R;
          r0  = mbt_pkg::make_res(mbt_pkg::OUT_RD, mbt_pkg::line_off('0), '0, 1'b0, 1'b1,
                                  base_seg);
          cnt = 2'd1;
        end
      end
      S_AH_R: begin
        if (dat) begin
          if (!hi_ok) begin
            // A line reads back the low pattern: stuck high.
            r0  = mbt_pkg::make_res(mbt_pkg::OUT_ADDR_REP, mbt_pkg::line_off(idx_line), '0,
                                    1'b0, 1'b1, base_seg);
            r1  = mbt_pkg::make_res(mbt_pkg::OUT_WR, '0, mbt_pkg::PAT_HI, 1'b0, 1'b1,
                                    base_seg);
            index_nxt = '0;
            state_nxt = S_RG_W;
            cnt = 2'd2;
          end else if (index_r < last_line_w) begin
            index_nxt = idx_inc;
            r0  = mbt_pkg::make_res(mbt_pkg::OUT_RD, mbt_pkg::line_off(idx_line_inc), '0,
                                    1'b0, 1'b1, base_seg);
            cnt = 2'd1;
          end else begin
            state_nxt = S_AR0_W;
            r0  = mbt_pkg::make_res(mbt_pkg::OUT_WR, '0, mbt_pkg::PAT_HI, 1'b0, 1'b1,
                                    base_seg);
            cnt = 2'd1;
          end
        end
      end
      S_AR0_W: begin
        if (ack) begin
          lut_nxt   = '0;
          state_nxt = S_AD_W;
          r0  = mbt_pkg::make_res(mbt_pkg::OUT_WR, mbt_pkg::line_off('0), mbt_pkg::PAT_LO,
                                  1'b0, 1'b1, base_seg);
          cnt = 2'd1;
        end
      end
      S_AD_W: begin
        if (ack) begin
          lbr_nxt   = '0;
          state_nxt = S_AL_R;
          r0  = mbt_pkg::make_res(mbt_pkg::OUT_RD, mbt_pkg::line_off('0), '0, 1'b0, 1'b1,
                                  base_seg);
          cnt = 2'd1;
        end
      end
      S_AL_R: begin
        if (dat) begin
          if (!hi_ok && (lbr_r != lut_r)) begin
            // Another line follows the driven one: stuck low or shorted.
            r0  = mbt_pkg::make_res(mbt_pkg::OUT_ADDR_REP, mbt_pkg::line_off(lut_r), '0,
                                    1'b0, 1'b1, base_seg);
            r1  = mbt_pkg::make_res(mbt_pkg::OUT_WR, '0, mbt_pkg::PAT_HI, 1'b0, 1'b1,
                                    base_seg);
            index_nxt = '0;
            state_nxt = S_RG_W;
            cnt = 2'd2;
          end else if (lbr_r < mbt_pkg::LAST_LINE) begin
            lbr_nxt = lbr_r + 1'b1;
            r0  = mbt_pkg::make_res(mbt_pkg::OUT_RD, mbt_pkg::line_off(lbr_r + 1'b1), '0,
                                    1'b0, 1'b1, base_seg);
            cnt = 2'd1;
          end else begin
            state_nxt = S_ARS_W;
            r0  = mbt_pkg::make_res(mbt_pkg::OUT_WR, mbt_pkg::line_off(lut_r),
                                    mbt_pkg::PAT_HI, 1'b0, 1'b1, base_seg);
            cnt = 2'd1;
          end
        end
      end
      S_ARS_W: begin
        if (ack) begin
          if (lut_r < mbt_pkg::LAST_LINE) begin
            lut_nxt   = lut_r + 1'b1;
            state_nxt = S_AD_W;
            r0  = mbt_pkg::make_res(mbt_pkg::OUT_WR, mbt_pkg::line_off(lut_r + 1'b1),
                                    mbt_pkg::PAT_LO, 1'b0, 1'b1, base_seg);
            cnt = 2'd1;
          end else begin
            // Every line checked out.
            r0  = mbt_pkg::make_res(mbt_pkg::OUT_ADDR_REP, '0, '0, 1'b1, 1'b1, base_seg);
            r1  = mbt_pkg::make_res(mbt_pkg::OUT_WR, '0, mbt_pkg::PAT_HI, 1'b0, 1'b1,
                                    base_seg);
            index_nxt = '0;
            state_nxt = S_RG_W;
            cnt = 2'd2;
          end
        end
      end
      S_RG_W: begin
        if (ack) begin
          cnt = 2'd1;
          if (index_r < mbt_pkg::RANGE_END) begin
            index_nxt = idx_inc;
            r0 = mbt_pkg::make_res(mbt_pkg::OUT_WR, mbt_pkg::LOFS_W'(idx_inc),
                                   mbt_pkg::PAT_HI, 1'b0, 1'b1, base_seg);
          end else begin
            index_nxt = '0;
            state_nxt = S_RG_R;
            r0 = mbt_pkg::make_res(mbt_pkg::OUT_RD, '0, '0, 1'b0, 1'b1, base_seg);
          end
        end
      end
      S_RG_R: begin
        if (dat) begin
          r0  = mbt_pkg::make_res(mbt_pkg::OUT_RANGE_REP, mbt_pkg::LOFS_W'(index_r), '0,
                                  hi_ok, 1'b1, base_seg);
          cnt = 2'd2;
          if (index_r < mbt_pkg::RANGE_END - 1'b1) begin
            index_nxt = idx_inc;
            r1 = mbt_pkg::make_res(mbt_pkg::OUT_RD, mbt_pkg::LOFS_W'(idx_inc), '0, 1'b0,
                                   1'b1, base_seg);
          end else begin
            index_nxt = '0;
            state_nxt = S_IDLE;
            r1 = mbt_pkg::make_res(mbt_pkg::OUT_DONE, '0, '0, 1'b0, 1'b0, base_seg);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // Flag the final result of this response.
    if (cnt == 2'd1) begin
      r0.last = 1'b1;
    end
    if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign res0    = r0;
  assign res1    = r1;
  assign res_cnt = cnt;

  // Sequencer state advances only when a response is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      index_r <= '0;
      lut_r   <= '0;
      lbr_r   <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      index_r <= index_nxt;
      lut_r   <= lut_nxt;
      lbr_r   <= lbr_nxt;
    end
  end

endmodule

// ===== rtl/mbt_out_fifo.sv =====
module mbt_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    push_cnt,
  input  mbt_pkg::res_t                 push0,
  input  mbt_pkg::res_t                 push1,
  input  logic                          pop,
  output mbt_pkg::res_t                 head,
  output logic [mbt_pkg::FIFO_CW-1:0]   count
);

  mbt_pkg::res_t                   mem_r [mbt_pkg::FIFO_DEPTH];
  logic [mbt_pkg::FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mbt_pkg::FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mbt_pkg::FIFO_CW-1:0]     cnt_r, cnt_nxt;

  assign wr_ptr_nxt = wr_ptr_r + mbt_pkg::FIFO_AW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + mbt_pkg::FIFO_AW'(pop);
  assign cnt_nxt    = cnt_r + mbt_pkg::FIFO_CW'(push_cnt) - mbt_pkg::FIFO_CW'(pop);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Up to two entries are written per cycle.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + 1'b1] <= push1;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

// ===== rtl/memory_bus_and_address_line_tester_core.sv =====
// Memory self-test bus master: walking ones on the data lines, walking patterns
// on the address lines, then a fill of offsets 0..0x800 and read-back of 0..0x7FF.
// Input channel (in_valid/in_stall): kind 0 starts a run while idle, kind 1
// acknowledges the last write, kind 2 returns the byte for the last read.
// Result channel (out_valid/out_stall): write and read requests, reports and a
// closing done item; out_last marks the final result caused by one input.
// Each input transfer yields zero, one or two results.
// Flow: an input transfer is registered, decided once the queue has room, and
// its results enter a four-entry output queue from which they are offered.
// Throughput: one input per cycle while the queue holds two free entries; the
// result channel moves one result per cycle while out_stall is low, which
// bounds inputs that yield two.
// When the receiver stalls, the queue fills and in_stall rises while an input
// is held; nothing is dropped.
// Configuration: cfg_base_segment is written when cfg_valid and cfg_ready are
// high; cfg_ready is always high. Physical address is segment*16 + offset.
// Reset (synchronous, rst_n low) returns the sequencer to idle, empties the
// queue and sets the segment to 0x280.
module memory_bus_and_address_line_tester_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mbt_pkg::KIND_W-1:0]      in_kind,
  input  logic [mbt_pkg::BYTE_W-1:0]      in_read_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mbt_pkg::OKIND_W-1:0]     out_kind,
  output logic [mbt_pkg::PHYS_W-1:0]      out_phys_address,
  output logic [mbt_pkg::OFS_W-1:0]       out_offset,
  output logic [mbt_pkg::BYTE_W-1:0]      out_data,
  output logic                            out_pass,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbt_pkg::SEG_W-1:0]       cfg_base_segment
);

  logic                            in_vld_r;
  logic [mbt_pkg::KIND_W-1:0]      in_kind_r;
  logic [mbt_pkg::BYTE_W-1:0]      in_rd_r;
  logic [mbt_pkg::SEG_W-1:0]       base_seg_r;
  logic                            in_xfer, step_en, out_xfer;
  logic [1:0]                      res_cnt, push_cnt;
  logic [mbt_pkg::FIFO_CW-1:0]     fifo_cnt;
  mbt_pkg::res_t                   res0, res1, head;

  // The held input is processed when the queue has room for two results.
  assign step_en   = in_vld_r && (fifo_cnt <= mbt_pkg::FIFO_CW'(mbt_pkg::FIFO_DEPTH - 2));
  assign in_stall  = in_vld_r && !step_en;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (fifo_cnt != '0);
  assign out_xfer  = out_valid && !out_stall;
  assign push_cnt  = step_en ? res_cnt : 2'd0;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_kind_r <= in_kind;
      in_rd_r   <= in_read_data;
    end
  end

  // Segment register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_seg_r <= mbt_pkg::SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_seg_r <= cfg_base_segment;
    end
  end

  mbt_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .kind     (in_kind_r),
    .rd       (in_rd_r),
    .base_seg (base_seg_r),
    .res0     (res0),
    .res1     (res1),
    .res_cnt  (res_cnt)
  );

  mbt_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push0    (res0),
    .push1    (res1),
    .pop      (out_xfer),
    .head     (head),
    .count    (fifo_cnt)
  );

  assign out_kind         = head.kind;
  assign out_phys_address = head.phys;
  assign out_offset       = head.offset;
  assign out_data         = head.data;
  assign out_pass         = head.pass;
  assign out_last         = head.last;

  // The queue never overflows.
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt <= mbt_pkg::FIFO_CW'(mbt_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  // A held input that is not processed keeps its contents.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !step_en |=> in_vld_r && $stable(in_kind_r) && $stable(in_rd_r))
    else $error("held input lost");

  // Pushed results are offered in the next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |=> out_valid)
    else $error("pushed result not offered");

  // Fill level tracks pushes and pops.
  a_fifo_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> fifo_cnt == mbt_pkg::FIFO_CW'($past(fifo_cnt)
      + mbt_pkg::FIFO_CW'($past(push_cnt)) - mbt_pkg::FIFO_CW'($past(out_xfer))))
    else $error("output queue count mismatch");

endmodule

// ===== dv/tb.sv =====
module tb;
  import mbt_pkg::*;

  // Input code that the block never accepts as a response.
  localparam logic [KIND_W-1:0] IN_NONE = 2'd3;
  localparam int CYCLE_LIMIT  = 2500000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CFG_EVERY    = 900;
  localparam res_t NO_RES     = '0;

  // Sequencer steps of the self-test, tracked by the predictor.
  typedef enum logic [3:0] {
    ST_IDLE, ST_DL_W, ST_DL_R, ST_AF_W, ST_AZ_W, ST_AH_R, ST_AR0_W,
    ST_AD_W, ST_AL_R, ST_ARS_W, ST_RG_W, ST_RG_R
  } tester_state_t;

  // One row of the directed script; typed rows carry their own results.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] rd;
    bit                typed;
    int                nres;
    res_t              r0;
    res_t              r1;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [BYTE_W-1:0]   in_read_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OKIND_W-1:0]  out_kind;
  logic [PHYS_W-1:0]   out_phys_address;
  logic [OFS_W-1:0]    out_offset;
  logic [BYTE_W-1:0]   out_data;
  logic                out_pass;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [SEG_W-1:0]    cfg_base_segment = '0;

  memory_bus_and_address_line_tester_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_read_data     (in_read_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_phys_address (out_phys_address),
    .out_offset       (out_offset),
    .out_data         (out_data),
    .out_pass         (out_pass),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_base_segment (cfg_base_segment)
  );

  always #2 clk = ~clk;

  // Predictor state, mirroring the sequencer after reset.
  tester_state_t     tester_st = ST_IDLE;
  logic [OFS_W-1:0]  step_idx = '0;
  logic [LINE_W-1:0] drive_line = '0;
  logic [LINE_W-1:0] read_line = '0;
  logic [SEG_W-1:0]  tester_seg = SEG_RESET;
  int                runs_done = 0;

  res_t step_out[$];
  res_t expected_results[$];
  stim_row_t script[$];

  int   errors = 0;
  int   cycles = 0;
  int   items = 0;
  int   hold_left = 0;
  bit   in_quiet = 1'b0;
  bit   out_quiet = 1'b0;

  function automatic logic [LOFS_W-1:0] line_offset(input logic [LINE_W-1:0] k);
    return LOFS_W'(1) << k;
  endfunction

  // Build one result at the current segment and append it to this step's results.
  function automatic void issue(input logic [OKIND_W-1:0] k, input logic [LOFS_W-1:0] off,
                                input logic [BYTE_W-1:0] d, input logic p,
                                input bit has_addr);
    res_t r;
    r.kind   = k;
    r.phys   = has_addr ? (PHYS_W'({tester_seg, 4'h0}) + PHYS_W'(off)) : '0;
    r.offset = has_addr ? off[OFS_W-1:0] : '0;
    r.data   = d;
    r.pass   = p;
    r.last   = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void begin_range_fill();
    step_idx  = '0;
    tester_st = ST_RG_W;
    issue(OUT_WR, '0, PAT_HI, 1'b0, 1'b1);
  endfunction

  // Advance the predicted sequencer by one accepted response.
  function automatic void step_tester(input logic [KIND_W-1:0] kind,
                                      input logic [BYTE_W-1:0] rd);
    bit ack;
    bit dat;
    logic [BYTE_W-1:0] pat;
    res_t fin;
    ack = (kind == IN_ACK);
    dat = (kind == IN_DATA);
    step_out.delete();
    case (tester_st)
      ST_IDLE: if (kind == IN_START) begin
        step_idx  = '0;
        tester_st = ST_DL_W;
        issue(OUT_WR, '0, 8'h01, 1'b0, 1'b1);
      end
      ST_DL_W: if (ack) begin
        tester_st = ST_DL_R;
        issue(OUT_RD, '0, '0, 1'b0, 1'b1);
      end
      ST_DL_R: if (dat) begin
        pat = BYTE_W'(1) << step_idx[2:0];
        issue(OUT_DATA_REP, '0, pat, rd == pat, 1'b1);
        if (step_idx < DATA_BITS - 1) begin
          step_idx  = step_idx + 1'b1;
          tester_st = ST_DL_W;
          issue(OUT_WR, '0, BYTE_W'(1) << step_idx[2:0], 1'b0, 1'b1);
        end else begin
          step_idx  = '0;
          tester_st = ST_AF_W;
          issue(OUT_WR, line_offset('0), PAT_HI, 1'b0, 1'b1);
        end
      end
      ST_AF_W: if (ack) begin
        if (step_idx < LAST_LINE) begin
          step_idx = step_idx + 1'b1;
          issue(OUT_WR, line_offset(step_idx[LINE_W-1:0]), PAT_HI, 1'b0, 1'b1);
        end else begin
          tester_st = ST_AZ_W;
          issue(OUT_WR, '0, PAT_LO, 1'b0, 1'b1);
        end
      end
      ST_AZ_W: if (ack) begin
        step_idx  = '0;
        tester_st = ST_AH_R;
        issue(OUT_RD, line_offset('0), '0, 1'b0, 1'b1);
      end
      ST_AH_R: if (dat) begin
        if (rd != PAT_HI) begin
          issue(OUT_ADDR_REP, line_offset(step_idx[LINE_W-1:0]), '0, 1'b0, 1'b1);
          begin_range_fill();
        end else if (step_idx < LAST_LINE) begin
          step_idx = step_idx + 1'b1;
          issue(OUT_RD, line_offset(step_idx[LINE_W-1:0]), '0, 1'b0, 1'b1);
        end else begin
          tester_st = ST_AR0_W;
          issue(OUT_WR, '0, PAT_HI, 1'b0, 1'b1);
        end
      end
      ST_AR0_W: if (ack) begin
        drive_line = '0;
        tester_st  = ST_AD_W;
        issue(OUT_WR, line_offset('0), PAT_LO, 1'b0, 1'b1);
      end
      ST_AD_W: if (ack) begin
        read_line = '0;
        tester_st = ST_AL_R;
        issue(OUT_RD, line_offset('0), '0, 1'b0, 1'b1);
      end
      ST_AL_R: if (dat) begin
        if (rd != PAT_HI && read_line != drive_line) begin
          issue(OUT_ADDR_REP, line_offset(drive_line), '0, 1'b0, 1'b1);
          begin_range_fill();
        end else if (read_line < LAST_LINE) begin
          read_line = read_line + 1'b1;
          issue(OUT_RD, line_offset(read_line), '0, 1'b0, 1'b1);
        end else begin
          tester_st = ST_ARS_W;
          issue(OUT_WR, line_offset(drive_line), PAT_HI, 1'b0, 1'b1);
        end
      end
      ST_ARS_W: if (ack) begin
        if (drive_line < LAST_LINE) begin
          drive_line = drive_line + 1'b1;
          tester_st  = ST_AD_W;
          issue(OUT_WR, line_offset(drive_line), PAT_LO, 1'b0, 1'b1);
        end else begin
          issue(OUT_ADDR_REP, '0, '0, 1'b1, 1'b1);
          begin_range_fill();
        end
      end
      ST_RG_W: if (ack) begin
        if (step_idx < RANGE_END) begin
          step_idx = step_idx + 1'b1;
          issue(OUT_WR, LOFS_W'(step_idx), PAT_HI, 1'b0, 1'b1);
        end else begin
          step_idx  = '0;
          tester_st = ST_RG_R;
          issue(OUT_RD, '0, '0, 1'b0, 1'b1);
        end
      end
      ST_RG_R: if (dat) begin
        issue(OUT_RANGE_REP, LOFS_W'(step_idx), '0, rd == PAT_HI, 1'b1);
        if (step_idx < RANGE_END - 1'b1) begin
          step_idx = step_idx + 1'b1;
          issue(OUT_RD, LOFS_W'(step_idx), '0, 1'b0, 1'b1);
        end else begin
          step_idx  = '0;
          tester_st = ST_IDLE;
          issue(OUT_DONE, '0, '0, 1'b0, 1'b0);
          runs_done++;
        end
      end
      default: tester_st = ST_IDLE;
    endcase
    // The final result of this transfer carries the last flag.
    if (step_out.size() != 0) begin
      fin = step_out.pop_back();
      fin.last = 1'b1;
      step_out.push_back(fin);
    end
  endfunction

  // Byte that a healthy memory returns for the read now pending.
  function automatic logic [BYTE_W-1:0] healthy_byte();
    case (tester_st)
      ST_DL_R: return BYTE_W'(1) << step_idx[2:0];
      ST_AL_R: return (read_line == drive_line) ? PAT_LO : PAT_HI;
      default: return PAT_HI;
    endcase
  endfunction

  // Each run leans toward one address-line outcome: stuck high, all good, stuck low.
  function automatic bit fault_now();
    int odds;
    int mode;
    mode = runs_done % 3;
    case (tester_st)
      ST_DL_R: odds = 4;
      ST_AH_R: odds = (mode == 0) ? 6 : 0;
      ST_AL_R: odds = (mode == 2) ? 40 : 0;
      default: odds = 16;
    endcase
    return odds != 0 && $urandom_range(0, odds - 1) == 0;
  endfunction

  function automatic stim_row_t make_row(input logic [KIND_W-1:0] kind,
                                         input logic [BYTE_W-1:0] rd, input bit typed,
                                         input int nres, input res_t r0, input res_t r1);
    stim_row_t row;
    row.kind  = kind;
    row.rd    = rd;
    row.typed = typed;
    row.nres  = nres;
    row.r0    = r0;
    row.r1    = r1;
    return row;
  endfunction

  // Offer one response after a random gap and predict on its transfer.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] rd,
                           input bit from_model);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_read_data <= rd;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    step_tester(kind, rd);
    items++;
    if (from_model) begin
      foreach (step_out[i]) expected_results.push_back(step_out[i]);
    end
  endtask

  // Stop offering input and let every outstanding result come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_segment(input logic [SEG_W-1:0] value);
    cfg_valid        <= 1'b1;
    cfg_base_segment <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    tester_seg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual kind %0h",
                 $time, out_kind);
      end else begin
        want = expected_results.pop_front();
        check_field("out_kind", 32'(want.kind), 32'(out_kind));
        check_field("out_phys_address", 32'(want.phys), 32'(out_phys_address));
        check_field("out_offset", 32'(want.offset), 32'(out_offset));
        check_field("out_data", 32'(want.data), 32'(out_data));
        check_field("out_pass", 32'(want.pass), 32'(out_pass));
        check_field("out_last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Receiver side: random stall after each transfer, with quiet stretches.
  always @(posedge clk) begin : receiver
    int hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if ($urandom_range(0, 199) == 0) out_quiet = !out_quiet;
      hold = out_quiet ? 0 : $urandom_range(0, 11);
      hold_left <= hold;
      out_stall <= (hold != 0);
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      out_stall <= !out_quiet && ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [KIND_W-1:0] kind;
    logic [KIND_W-1:0] right;
    logic [BYTE_W-1:0] rd;
    logic [SEG_W-1:0]  seg;
    int since_cfg;
    int cfg_writes;

    // Directed script at the reset segment: ignored responses, the first data-line
    // checks with passing and failing bytes, and the step into the address phase.
    script.push_back(make_row(IN_ACK, 8'h00, 1'b1, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'hFF, 1'b1, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_NONE, 8'h5A, 1'b1, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_START, 8'h00, 1'b1, 1,
                              {OUT_WR, 20'h02800, 12'h000, 8'h01, 1'b0, 1'b1}, NO_RES));
    script.push_back(make_row(IN_START, 8'hFF, 1'b1, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'h00, 1'b1, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_ACK, 8'h00, 1'b1, 1,
                              {OUT_RD, 20'h02800, 12'h000, 8'h00, 1'b0, 1'b1}, NO_RES));
    script.push_back(make_row(IN_ACK, 8'h00, 1'b1, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'h01, 1'b1, 2,
                              {OUT_DATA_REP, 20'h02800, 12'h000, 8'h01, 1'b1, 1'b0},
                              {OUT_WR, 20'h02800, 12'h000, 8'h02, 1'b0, 1'b1}));
    script.push_back(make_row(IN_ACK, 8'hFF, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'h00, 1'b1, 2,
                              {OUT_DATA_REP, 20'h02800, 12'h000, 8'h02, 1'b0, 1'b0},
                              {OUT_WR, 20'h02800, 12'h000, 8'h04, 1'b0, 1'b1}));
    script.push_back(make_row(IN_ACK, 8'h00, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'hFF, 1'b1, 2,
                              {OUT_DATA_REP, 20'h02800, 12'h000, 8'h04, 1'b0, 1'b0},
                              {OUT_WR, 20'h02800, 12'h000, 8'h08, 1'b0, 1'b1}));
    script.push_back(make_row(IN_ACK, 8'h00, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'h08, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_ACK, 8'h00, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'h10, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_ACK, 8'h00, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'h20, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_ACK, 8'h00, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'h40, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_ACK, 8'h00, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_DATA, 8'h80, 1'b1, 2,
                              {OUT_DATA_REP, 20'h02800, 12'h000, 8'h80, 1'b1, 1'b0},
                              {OUT_WR, 20'h02801, 12'h001, 8'hAA, 1'b0, 1'b1}));
    script.push_back(make_row(IN_ACK, 8'h00, 1'b0, 0, NO_RES, NO_RES));
    script.push_back(make_row(IN_NONE, 8'hA5, 1'b1, 0, NO_RES, NO_RES));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_item(script[i].kind, script[i].rd, !script[i].typed);
      if (script[i].typed && script[i].nres > 0) expected_results.push_back(script[i].r0);
      if (script[i].typed && script[i].nres > 1) expected_results.push_back(script[i].r1);
    end

    // Random part: act as the memory, mostly answering correctly, with injected
    // faults, ignored noise and segment changes while nothing is in flight.
    since_cfg  = CFG_EVERY;
    cfg_writes = 0;
    while (items < RANDOM_ITEMS) begin
      if (since_cfg >= CFG_EVERY) begin
        drain_results();
        case (cfg_writes)
          0: seg = '1;
          1: seg = '0;
          default: begin
            case ($urandom_range(0, 3))
              0: seg = '0;
              1: seg = '1;
              default: seg = SEG_W'($urandom);
            endcase
          end
        endcase
        write_segment(seg);
        cfg_writes++;
        since_cfg = 0;
      end

      case (tester_st)
        ST_IDLE: right = IN_START;
        ST_DL_R, ST_AH_R, ST_AL_R, ST_RG_R: right = IN_DATA;
        default: right = IN_ACK;
      endcase
      rd = BYTE_W'($urandom);
      if ($urandom_range(0, 11) == 0) begin
        // Noise: any response the sequencer must ignore right now.
        kind = KIND_W'($urandom_range(0, 3));
        while (kind == right) kind = KIND_W'($urandom_range(0, 3));
      end else begin
        kind = right;
        if (right == IN_DATA && !fault_now()) rd = healthy_byte();
      end

      send_item(kind, rd, 1'b1);
      since_cfg++;
      if ($urandom_range(0, 199) == 0) in_quiet = !in_quiet;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
